>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, disabled while reset is high.
`define ASSERT_AT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Condition that must never be true on a clock edge.
`define ASSERT_NEVER(label, clk, rst, cond) \
  `ASSERT_AT(label, clk, rst, !(cond))

`endif

>>> rtl/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg
// Types, codes and defaults shared by the page framebuffer pixel engine.
// ----------------------------------------------------------------------------
package pfb_pkg;

  // Default panel geometry
  localparam int PANEL_WIDTH_DEF  = 84;
  localparam int PANEL_HEIGHT_DEF = 48;

  // Address space reachable from 8-bit physical coordinates (page * width + column)
  localparam int FULL_ADDR_W = 14;

  // Command codes
  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Color codes
  localparam logic [7:0] COLOR_CLEAR  = 8'd0;
  localparam logic [7:0] COLOR_SET    = 8'd1;
  localparam logic [7:0] COLOR_TOGGLE = 8'd2;

  // Rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef logic [1:0] rot_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [7:0]         color;
    logic [8:0]         byte_index;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       last_byte;
    logic       clipped;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;
    logic calc;
    logic commit;
    logic clr_step;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_clear;
    logic clr_last;
  } dp_status_t;

endpackage

>>> rtl/pfb_ram.sv
// ----------------------------------------------------------------------------
// pfb_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 504
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write when enabled; registered read returns the old byte during a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/pfb_datapath.sv
// ----------------------------------------------------------------------------
// pfb_datapath
// Request register, clip and rotation mapping, frame store, clear counter
// and response register.
// ----------------------------------------------------------------------------
module pfb_datapath #(
  parameter int PANEL_WIDTH  = pfb_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = pfb_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pfb_pkg::req_t        req,
  input  logic                 cfg_write,
  input  pfb_pkg::rot_t        cfg_data,
  input  pfb_pkg::ctl_cmd_t    ctl,
  output pfb_pkg::dp_status_t  status,
  output pfb_pkg::rsp_t        rsp
);
  import pfb_pkg::*;

  localparam int STORE_BYTES = PANEL_WIDTH * (PANEL_HEIGHT / 8);
  localparam int AW          = $clog2(STORE_BYTES);

  localparam logic [7:0] W8  = 8'(PANEL_WIDTH);
  localparam logic [7:0] H8  = 8'(PANEL_HEIGHT);
  localparam logic [7:0] WM1 = 8'(PANEL_WIDTH - 1);
  localparam logic [7:0] HM1 = 8'(PANEL_HEIGHT - 1);
  localparam logic [FULL_ADDR_W-1:0] STORE_FULL = FULL_ADDR_W'(STORE_BYTES);
  localparam logic [FULL_ADDR_W-1:0] LAST_FULL  = FULL_ADDR_W'(STORE_BYTES - 1);
  localparam logic [AW-1:0]          LAST_ADDR  = AW'(STORE_BYTES - 1);

  req_t          req_q;
  rot_t          rotation;
  logic [AW-1:0] addr_q;
  logic [2:0]    bit_q;
  logic          hit_q;
  logic          clip_q;
  logic          last_q;
  logic [AW-1:0] clr_cnt;
  rsp_t          rsp_q;

  logic                   swapped;
  logic [7:0]             rw;
  logic [7:0]             rh;
  logic                   clip;
  logic [7:0]             px;
  logic [7:0]             py;
  logic [FULL_ADDR_W-1:0] draw_full;
  logic [FULL_ADDR_W-1:0] idx_full;
  logic [FULL_ADDR_W-1:0] addr_calc;
  logic                   hit_calc;
  logic                   last_calc;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    rdata;
  logic [7:0]    mask;
  logic [7:0]    modified;
  logic          is_draw;
  logic          is_read;

  // Hold the rotation register
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= ROT_0;
    end else if (cfg_write) begin
      rotation <= cfg_data;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      req_q <= req;
    end
  end

  // Clip against the rotated panel
  always_comb begin
    swapped = (rotation == ROT_90) || (rotation == ROT_270);
    rw      = swapped ? H8 : W8;
    rh      = swapped ? W8 : H8;
    clip    = req_q.x[15] || (req_q.x[14:0] >= 15'(rw)) ||
              req_q.y[15] || (req_q.y[14:0] >= 15'(rh));
  end

  // Map rotated point to the physical panel
  always_comb begin
    case (rotation)
      ROT_90: begin
        px = req_q.y[7:0];
        py = HM1 - req_q.x[7:0];
      end
      ROT_180: begin
        px = WM1 - req_q.x[7:0];
        py = HM1 - req_q.y[7:0];
      end
      ROT_270: begin
        px = WM1 - req_q.y[7:0];
        py = req_q.x[7:0];
      end
      default: begin
        px = req_q.x[7:0];
        py = req_q.y[7:0];
      end
    endcase
  end

  // Form the byte address for draw or read
  always_comb begin
    draw_full = FULL_ADDR_W'(py[7:3]) * FULL_ADDR_W'(W8) + FULL_ADDR_W'(px);
    idx_full  = FULL_ADDR_W'(req_q.byte_index);
    if (req_q.cmd == CMD_READ) begin
      addr_calc = idx_full;
      hit_calc  = idx_full < STORE_FULL;
      last_calc = idx_full == LAST_FULL;
    end else begin
      addr_calc = draw_full;
      hit_calc  = !clip && (draw_full < STORE_FULL);
      last_calc = 1'b0;
    end
  end

  // Register the address stage
  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      addr_q <= addr_calc[AW-1:0];
      bit_q  <= py[2:0];
      hit_q  <= hit_calc;
      clip_q <= clip;
      last_q <= last_calc;
    end
  end

  // Advance the clear sweep; restart it when a clear request commits
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (ctl.commit && status.is_clear) begin
      clr_cnt <= '0;
    end else if (ctl.clr_step) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Modify the fetched byte
  always_comb begin
    is_draw = req_q.cmd == CMD_DRAW;
    is_read = req_q.cmd == CMD_READ;
    mask    = 8'd1 << bit_q;
    case (req_q.color)
      COLOR_SET:    modified = rdata | mask;
      COLOR_CLEAR:  modified = rdata & ~mask;
      COLOR_TOGGLE: modified = rdata ^ mask;
      default:      modified = rdata;
    endcase
  end

  // Steer the store port between the sweep and read-modify-write
  always_comb begin
    ram_we    = ctl.clr_step || (ctl.commit && is_draw && hit_q);
    ram_addr  = ctl.clr_step ? clr_cnt : addr_q;
    ram_wdata = ctl.clr_step ? 8'd0 : modified;
  end

  pfb_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (rdata)
  );

  // Load the response on commit
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      rsp_q.read_data <= (is_read && hit_q) ? rdata : 8'd0;
      rsp_q.last_byte <= is_read && last_q;
      rsp_q.clipped   <= is_draw && clip_q;
    end
  end

  assign rsp             = rsp_q;
  assign status.is_clear = req_q.cmd == CMD_CLEAR;
  assign status.clr_last = clr_cnt == LAST_ADDR;

endmodule

>>> rtl/pfb_ctrl.sv
// ----------------------------------------------------------------------------
// pfb_ctrl
// Sequencer: clear sweep, request intake, address, fetch, commit, and the
// response valid flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  input  pfb_pkg::dp_status_t status,
  output pfb_pkg::ctl_cmd_t   ctl
);
  import pfb_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_CALC  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_MOD   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       slot_free;

  assign req_stall = state != ST_IDLE;
  assign slot_free = !rsp_valid || !rsp_stall;

  // Issue commands for the current state
  always_comb begin
    ctl          = '0;
    ctl.load_req = (state == ST_IDLE) && req_valid;
    ctl.calc     = state == ST_CALC;
    ctl.commit   = (state == ST_MOD) && slot_free;
    ctl.clr_step = state == ST_CLEAR;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (status.clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (req_valid) state_next = ST_CALC;
      ST_CALC:  state_next = ST_READ;
      ST_READ:  state_next = ST_MOD;
      ST_MOD: begin
        if (slot_free) begin
          state_next = status.is_clear ? ST_CLEAR : ST_IDLE;
        end
      end
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Sweep the store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Hold the response until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  `ASSERT_AT(a_commit_slot_free, clk, rst, ctl.commit |-> (!rsp_valid || !rsp_stall))
  `ASSERT_NEVER(a_commit_during_sweep, clk, rst, ctl.commit && ctl.clr_step)
  `ASSERT_AT(a_accept_starts_calc, clk, rst, (req_valid && !req_stall) |=> (state == ST_CALC))

endmodule

>>> rtl/page_framebuffer_pixel_engine.sv
// ----------------------------------------------------------------------------
// page_framebuffer_pixel_engine
// Monochrome page framebuffer: draw, clear and read of an 8-pixel-per-byte
// frame store with four display rotations.
//
//   channel  | signals                       | direction
//   ---------+-------------------------------+----------
//   request  | req_valid, req_stall, req     | in
//   response | rsp_valid, rsp_stall, rsp     | out
//   config   | cfg_write, cfg_data           | in
//
// A draw, read or unused command goes from accept through address compute,
// store fetch, then modify/write and response load before the next accept.
// A clear adds a sweep of all PANEL_WIDTH * (PANEL_HEIGHT / 8) bytes (504 at the
// default size) through the single store port; its response is loaded first.
// After reset the same sweep runs before the first request is taken.
// A stalled response holds the engine in its commit step; a new request is
// taken while an earlier response still waits.
// ----------------------------------------------------------------------------
module page_framebuffer_pixel_engine #(
  parameter int PANEL_WIDTH  = pfb_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = pfb_pkg::PANEL_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pfb_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pfb_pkg::rsp_t rsp,
  input  logic          cfg_write,
  input  pfb_pkg::rot_t cfg_data
);
  import pfb_pkg::*;

  ctl_cmd_t   ctl;
  dp_status_t status;

  pfb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .ctl       (ctl)
  );

  pfb_datapath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .status    (status),
    .rsp       (rsp)
  );

endmodule
